### hdl/elft_pkg.sv
// Package with the types, constants and sequencer encodings of the link frame timing block.
`default_nettype none

package elft_pkg;

    localparam int OPCODE_W    = 1;
    localparam int FRAME_W     = 11;
    localparam int TIME_W      = 63;
    localparam int RATE_W      = 39;
    localparam int PROP_W      = 32;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 39;

    localparam int FRAME_MAX       = 2 ** FRAME_W - 1;
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int MIN_MAC_BYTES   = 64;
    localparam int FCS_BYTES       = 4;
    localparam int PREAMBLE_BYTES  = 8;
    localparam int GAP_BYTES       = 12;

    localparam logic [29:0] NS_PER_SEC = 30'd1_000_000_000;
    localparam longint unsigned RATE_MAX = 64'd549_755_813_887;

    localparam logic [RATE_W-1:0] RATE_RESET = 39'd1_000_000_000;
    localparam logic [PROP_W-1:0] PROP_RESET = 32'd0;
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

    localparam logic [OPCODE_W-1:0] OP_TRANSMIT = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_DRAIN    = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_RATE   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROPAGATION = 4'd1;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [FRAME_W-1:0]  frame_bytes;
        logic [TIME_W-1:0]   now_ns;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] start_ns;
        logic [TIME_W-1:0] delivery_ns;
        logic [TIME_W-1:0] next_free_ns;
    } out_item_t;

    typedef logic [2:0] pc_t;

    localparam pc_t STEP_IDLE = 3'd0;
    localparam pc_t STEP_DIV  = 3'd3;
    localparam pc_t STEP_EMIT = 3'd6;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_DECODE,
        ACT_SETUP,
        ACT_DIV,
        ACT_SUM1,
        ACT_SUM2,
        ACT_EMIT
    } act_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DRAIN,
        COND_DIV_MORE,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        pc_t   target;
    } ucode_t;

    typedef struct packed {
        logic in_fire;
        logic drain;
        logic div_more;
        logic out_free;
    } elft_status_t;

endpackage

`default_nettype wire

### hdl/elft_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module elft_seq
    import elft_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  elft_status_t status,
    output ucode_t       ctl
);

    pc_t  pc_reg;
    pc_t  pc_next;
    logic take;

    function automatic ucode_t rom(input pc_t pc);
        ucode_t w;
        unique case (pc)
            3'd0:    w = '{act: ACT_ACCEPT, cond: COND_NO_INPUT, target: STEP_IDLE};
            3'd1:    w = '{act: ACT_DECODE, cond: COND_DRAIN,    target: STEP_IDLE};
            3'd2:    w = '{act: ACT_SETUP,  cond: COND_NEVER,    target: STEP_IDLE};
            3'd3:    w = '{act: ACT_DIV,    cond: COND_DIV_MORE, target: STEP_DIV};
            3'd4:    w = '{act: ACT_SUM1,   cond: COND_NEVER,    target: STEP_IDLE};
            3'd5:    w = '{act: ACT_SUM2,   cond: COND_NEVER,    target: STEP_IDLE};
            3'd6:    w = '{act: ACT_EMIT,   cond: COND_OUT_FREE, target: STEP_IDLE};
            3'd7:    w = '{act: ACT_NONE,   cond: COND_ALWAYS,   target: STEP_EMIT};
            default: w = '{act: ACT_NONE,   cond: COND_ALWAYS,   target: STEP_IDLE};
        endcase
        return w;
    endfunction

    assign ctl = rom(pc_reg);

    always_comb
    begin
        unique case (ctl.cond)
            COND_ALWAYS:   take = 1'b1;
            COND_NO_INPUT: take = !status.in_fire;
            COND_DRAIN:    take = status.drain;
            COND_DIV_MORE: take = status.div_more;
            COND_OUT_FREE: take = status.out_free;
            default:       take = 1'b0;
        endcase
        pc_next = take ? ctl.target : pc_t'(pc_reg + 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

### hdl/ethernet_link_frame_timing.sv
// Top level of the link frame timing engine: ports, datapath and configuration registers.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid / in_ready    in_data (in_item_t)
//   out       output     out_valid / out_ready  out_data (out_item_t)
//   cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A transmit item runs through accept, decode, setup, division, two sums and emit; the division
// uses the two radix-2 dividers that run side by side, one quotient bit per cycle.
// A drain item goes through accept and decode only. Configuration writes are taken in every cycle.
// A finished result waits in the output register; the next item is accepted meanwhile, and
// the sequencer waits at its emit step while that register is full and out_ready is low.
// Reset clears the transmitter busy time and loads the register defaults.
`default_nettype none

module ethernet_link_frame_timing
    import elft_pkg::*;
#(
    parameter int MAX_FRAME_BYTES_P = MAX_FRAME_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LEN_CAP = (MAX_FRAME_BYTES_P < FRAME_MAX) ? MAX_FRAME_BYTES_P : FRAME_MAX;
    localparam int MAC_MAX = (LEN_CAP + FCS_BYTES > MIN_MAC_BYTES) ?
                             LEN_CAP + FCS_BYTES : MIN_MAC_BYTES;
    localparam int SBITS_MAX = (MAC_MAX + PREAMBLE_BYTES + GAP_BYTES) * 8;
    localparam int MAC_W  = $clog2(MAC_MAX + 1);
    localparam int BITS_W = $clog2(SBITS_MAX + 1);
    localparam longint unsigned NUM_MAX = longint'(SBITS_MAX) * longint'(NS_PER_SEC) + RATE_MAX;
    localparam int NUM_W = $clog2(NUM_MAX + 1);
    localparam int CNT_W = $clog2(NUM_W + 1);

    ucode_t       ctl;
    elft_status_t status;

    logic [RATE_W-1:0] rate_reg;
    logic [PROP_W-1:0] prop_reg;
    logic [TIME_W-1:0] free_reg;
    logic              out_valid_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [OPCODE_W-1:0] opcode_reg;
    logic [FRAME_W-1:0]  len_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [BITS_W-1:0]   bits_reg [2];
    logic [TIME_W-1:0]   start_reg;
    logic [NUM_W-1:0]    quo_reg [2];
    logic [RATE_W-1:0]   rem_reg [2];
    logic [TIME_W-1:0]   nfree_reg;
    logic [TIME_W-1:0]   tdel_reg;
    logic [TIME_W-1:0]   deliv_reg;
    out_item_t           out_reg;

    logic                in_fire;
    logic                emit_fire;
    logic [RATE_W-1:0]   divisor;
    logic [FRAME_W-1:0]  len_eff;
    logic [MAC_W-1:0]    mac;
    logic [BITS_W-1:0]   bits_next [2];
    logic [NUM_W-1:0]    num_next [2];
    logic [RATE_W:0]     shifted [2];
    logic [RATE_W:0]     diff [2];
    logic [NUM_W-1:0]    quo_next [2];
    logic [RATE_W-1:0]   rem_next [2];
    logic [TIME_W:0]     sum_free;
    logic [TIME_W:0]     sum_del;
    logic [TIME_W:0]     sum_prop;

    elft_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    assign in_ready  = (ctl.act == ACT_ACCEPT);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign status.in_fire  = in_fire;
    assign status.drain    = (opcode_reg == OP_DRAIN);
    assign status.div_more = (count_reg != CNT_W'(1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign emit_fire = (ctl.act == ACT_EMIT) && status.out_free;
    assign divisor   = (rate_reg == '0) ? RATE_W'(1) : rate_reg;

    always_comb
    begin
        len_eff = (FRAME_W'(LEN_CAP) < len_reg) ? FRAME_W'(LEN_CAP) : len_reg;
        mac     = MAC_W'(len_eff) + MAC_W'(FCS_BYTES);
        if (mac < MAC_W'(MIN_MAC_BYTES))
        begin
            mac = MAC_W'(MIN_MAC_BYTES);
        end
        bits_next[0] = BITS_W'(BITS_W'(mac) + BITS_W'(PREAMBLE_BYTES)) << 3;
        bits_next[1] = BITS_W'(BITS_W'(mac) + BITS_W'(PREAMBLE_BYTES + GAP_BYTES)) << 3;
        for (int i = 0; i < 2; i++)
        begin
            num_next[i] = NUM_W'(bits_reg[i]) * NUM_W'(NS_PER_SEC)
                        + NUM_W'(divisor - RATE_W'(1));
            shifted[i]  = {rem_reg[i], quo_reg[i][NUM_W-1]};
            diff[i]     = shifted[i] - {1'b0, divisor};
            if (shifted[i] >= {1'b0, divisor})
            begin
                rem_next[i] = diff[i][RATE_W-1:0];
                quo_next[i] = {quo_reg[i][NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = shifted[i][RATE_W-1:0];
                quo_next[i] = {quo_reg[i][NUM_W-2:0], 1'b0};
            end
        end
        sum_free = {1'b0, start_reg} + (TIME_W + 1)'(quo_reg[1]);
        sum_del  = {1'b0, start_reg} + (TIME_W + 1)'(quo_reg[0]);
        sum_prop = {1'b0, tdel_reg} + (TIME_W + 1)'(prop_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= RATE_RESET;
            prop_reg      <= PROP_RESET;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LINE_RATE:   rate_reg <= cfg_data[RATE_W-1:0];
                    REG_PROPAGATION: prop_reg <= cfg_data[PROP_W-1:0];
                    default:         ;
                endcase
            end
            if ((ctl.act == ACT_DECODE) && status.drain)
            begin
                free_reg <= '0;
            end
            else if (emit_fire)
            begin
                free_reg <= nfree_reg;
            end
            if (ctl.act == ACT_SETUP)
            begin
                count_reg <= CNT_W'(NUM_W);
            end
            else if (ctl.act == ACT_DIV)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            opcode_reg <= in_data.opcode;
            len_reg    <= in_data.frame_bytes;
            now_reg    <= in_data.now_ns;
        end
        if (ctl.act == ACT_DECODE)
        begin
            bits_reg[0] <= bits_next[0];
            bits_reg[1] <= bits_next[1];
        end
        if (ctl.act == ACT_SETUP)
        begin
            start_reg <= (now_reg > free_reg) ? now_reg : free_reg;
            for (int i = 0; i < 2; i++)
            begin
                quo_reg[i] <= num_next[i];
                rem_reg[i] <= '0;
            end
        end
        if (ctl.act == ACT_DIV)
        begin
            for (int i = 0; i < 2; i++)
            begin
                quo_reg[i] <= quo_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
        if (ctl.act == ACT_SUM1)
        begin
            nfree_reg <= sum_free[TIME_W] ? TIME_MAX : sum_free[TIME_W-1:0];
            tdel_reg  <= sum_del[TIME_W] ? TIME_MAX : sum_del[TIME_W-1:0];
        end
        if (ctl.act == ACT_SUM2)
        begin
            deliv_reg <= sum_prop[TIME_W] ? TIME_MAX : sum_prop[TIME_W-1:0];
        end
        if (emit_fire)
        begin
            out_reg.start_ns     <= start_reg;
            out_reg.delivery_ns  <= deliv_reg;
            out_reg.next_free_ns <= nfree_reg;
        end
    end

    // A result never starts after its own delivery or the next free time.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.start_ns <= out_data.next_free_ns)
                   && (out_data.start_ns <= out_data.delivery_ns))
        else $error("result times out of order");

    // The partial remainders stay below the divisor throughout the division.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.act == ACT_DIV) |-> (rem_reg[0] < divisor) && (rem_reg[1] < divisor))
        else $error("divider remainder not below divisor");

    // After a result is emitted the transmitter is busy at least until its start.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (free_reg >= $past(start_reg)))
        else $error("transmitter free time moved before frame start");

    // A drain item clears the busy time and returns to idle without a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.act == ACT_DECODE) && status.drain
            |=> (free_reg == '0) && in_ready && ($past(out_valid) || !out_valid))
        else $error("drain item handled wrongly");

endmodule

`default_nettype wire

### tb/tb_ethernet_link_frame_timing.sv
// Self-checking testbench for the Ethernet link frame timing engine.
`timescale 1ns / 100ps

module tb_ethernet_link_frame_timing
    import elft_pkg::*;
;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 165;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    in_item_t          frames_to_send[$];
    out_item_t         due_timing_q[$];
    longint unsigned   model_rate = RATE_RESET;
    longint unsigned   model_prop = PROP_RESET;
    longint unsigned   busy_until = 0;
    longint unsigned   now_cursor = 0;
    int                mismatch_count = 0;
    int                cycle_count = 0;
    int                idle_pct = 0;
    logic              calm = 1'b0;
    int                in_gap = 0;
    int                out_stall = 0;

    ethernet_link_frame_timing i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned wire_time_ns(longint unsigned bits);
        longint unsigned rate;
        rate = (model_rate == 0) ? 64'd1 : model_rate;
        return (bits * 64'd1_000_000_000 + rate - 64'd1) / rate;
    endfunction

    function automatic longint unsigned time_sum(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > TIME_MAX) ? TIME_MAX : s;
    endfunction

    function automatic void book_frame(in_item_t it);
        longint unsigned len;
        longint unsigned mac;
        longint unsigned start;
        longint unsigned deliv;
        longint unsigned nfree;
        out_item_t       r;
        if (it.opcode == OP_DRAIN)
        begin
            busy_until = 0;
            return;
        end
        len = it.frame_bytes;
        if (len > MAX_FRAME_BYTES)
            len = MAX_FRAME_BYTES;
        mac = len + FCS_BYTES;
        if (mac < MIN_MAC_BYTES)
            mac = MIN_MAC_BYTES;
        start = (it.now_ns > busy_until) ? it.now_ns : busy_until;
        nfree = time_sum(start, wire_time_ns((PREAMBLE_BYTES + mac + GAP_BYTES) * 8));
        deliv = time_sum(time_sum(start, wire_time_ns((PREAMBLE_BYTES + mac) * 8)), model_prop);
        busy_until = nfree;
        r.start_ns     = start[TIME_W-1:0];
        r.delivery_ns  = deliv[TIME_W-1:0];
        r.next_free_ns = nfree[TIME_W-1:0];
        due_timing_q.insert(due_timing_q.size(), r);
    endfunction

    function automatic void queue_frame(logic [OPCODE_W-1:0] op, int unsigned bytes,
                                        longint unsigned at);
        in_item_t it;
        it.opcode      = op;
        it.frame_bytes = FRAME_W'(bytes);
        it.now_ns      = TIME_W'(at);
        frames_to_send.insert(frames_to_send.size(), it);
    endfunction

    function automatic void queue_random_frame();
        longint unsigned span;
        longint unsigned r;
        logic [FRAME_W-1:0] bytes;
        int unsigned pick;
        case ($urandom_range(0, 3))
            0: bytes = FRAME_W'($urandom_range(0, 70));
            1: bytes = FRAME_W'($urandom_range(0, FRAME_MAX));
            default: bytes = FRAME_W'($urandom_range(40, 1600));
        endcase
        span = wire_time_ns(12336);
        r = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 80)
            now_cursor = (now_cursor + r % (2 * span + 1)) & TIME_MAX;
        else if (pick < 90)
            now_cursor = r & TIME_MAX;
        else if (pick < 95)
            now_cursor = TIME_MAX - $urandom_range(0, 100000);
        else
            now_cursor = $urandom_range(0, 1000);
        queue_frame(($urandom_range(0, 99) < 6) ? OP_DRAIN : OP_TRANSMIT, bytes,
                    now_cursor[TIME_W-1:0]);
    endfunction

    function automatic void check_time(string name, logic [TIME_W-1:0] want,
                                       logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_LINE_RATE)
            model_rate = val;
        else if (idx == REG_PROPAGATION)
            model_prop = val[PROP_W-1:0];
    endtask

    task automatic settle();
        while (frames_to_send.size() != 0 || in_valid || due_timing_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : feed
        logic     next_valid;
        in_item_t next_item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end
        else
        begin
            next_valid = in_valid;
            next_item  = in_data;
            if (in_valid && in_ready)
            begin
                book_frame(in_data);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
                else if (frames_to_send.size() != 0)
                begin
                    if (!calm && $urandom_range(0, 99) < idle_pct)
                        in_gap <= $urandom_range(0, 13);
                    else
                    begin
                        next_item  = frames_to_send.pop_front();
                        next_valid = 1'b1;
                    end
                end
            end
            in_valid <= next_valid;
            in_data  <= next_item;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : observe
        out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_timing_q.size() == 0)
                begin
                    $display("%0t: transfer expected none, actual %p", $time, out_data);
                    mismatch_count++;
                end
                else
                begin
                    want = due_timing_q.pop_front();
                    check_time("start_ns", want.start_ns, out_data.start_ns);
                    check_time("delivery_ns", want.delivery_ns, out_data.delivery_ns);
                    check_time("next_free_ns", want.next_free_ns, out_data.next_free_ns);
                end
            end
            if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < idle_pct)
            begin
                out_stall <= $urandom_range(0, 13);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int              ph;
        int              idx;
        longint unsigned r;
        longint unsigned rate_pick;
        longint unsigned prop_pick;

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Default rate: padding edges, back-to-back frames, drain, saturation.
        queue_frame(OP_TRANSMIT, 0, 0);
        queue_frame(OP_TRANSMIT, 59, 0);
        queue_frame(OP_TRANSMIT, 60, 100);
        queue_frame(OP_TRANSMIT, 61, 5000);
        queue_frame(OP_TRANSMIT, FRAME_MAX, 5000);
        queue_frame(OP_DRAIN, FRAME_MAX, TIME_MAX);
        queue_frame(OP_TRANSMIT, 1, 10);
        queue_frame(OP_TRANSMIT, 1024, 20);
        queue_frame(OP_TRANSMIT, 0, TIME_MAX);
        queue_frame(OP_TRANSMIT, 1500, TIME_MAX - 100);
        queue_frame(OP_DRAIN, 0, 0);
        queue_frame(OP_TRANSMIT, 11'h2AA, {21{3'b010}});
        queue_frame(OP_TRANSMIT, 11'h555, {21{3'b101}});
        settle();

        for (idx = REG_PROPAGATION + 1; idx < 2 ** CFG_INDEX_W; idx++)
        begin
            r = {$urandom, $urandom};
            write_reg(idx[CFG_INDEX_W-1:0], r[CFG_DATA_W-1:0]);
        end
        write_reg(REG_LINE_RATE, '0);
        write_reg(REG_PROPAGATION, {PROP_W{1'b1}});
        queue_frame(OP_TRANSMIT, 0, 0);
        queue_frame(OP_TRANSMIT, FRAME_MAX, 0);
        queue_frame(OP_TRANSMIT, 64, TIME_MAX - 1000);
        queue_frame(OP_DRAIN, 5, 7);
        queue_frame(OP_TRANSMIT, 100, 1);
        settle();

        write_reg(REG_LINE_RATE, {CFG_DATA_W{1'b1}});
        write_reg(REG_PROPAGATION, '0);
        queue_frame(OP_TRANSMIT, 0, 0);
        queue_frame(OP_TRANSMIT, FRAME_MAX, 1);
        queue_frame(OP_TRANSMIT, 11'h555, 2);
        queue_frame(OP_TRANSMIT, 11'h2AA, 3);
        settle();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            r = {$urandom, $urandom};
            case ($urandom_range(0, 4))
                0: rate_pick = 64'd1_000_000_000;
                1: rate_pick = r[RATE_W-1:0];
                2: rate_pick = $urandom_range(0, 10000);
                3: rate_pick = 64'd400_000_000_000 - $urandom_range(0, 1000);
                default: rate_pick = 64'd10_000_000 * $urandom_range(1, 40000);
            endcase
            r = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: prop_pick = 0;
                1: prop_pick = r[PROP_W-1:0];
                2: prop_pick = r[CFG_DATA_W-1:0];
                default: prop_pick = $urandom_range(0, 5000);
            endcase
            write_reg(REG_LINE_RATE, rate_pick[CFG_DATA_W-1:0]);
            write_reg(REG_PROPAGATION, prop_pick[CFG_DATA_W-1:0]);
            idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 15 : 40);
            calm = (ph == RANDOM_PHASES - 1);
            now_cursor = $urandom_range(0, 100000);
            repeat (PHASE_ITEMS) queue_random_frame();
            settle();
        end

        if (mismatch_count == 0 && due_timing_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
